// ----- rtl/brf_pkg.sv -----
package brf_pkg;

    // sizing of the store
    localparam int MAX_BLOCK_WORDS  = 16;
    localparam int MAX_DEPTH_BLOCKS = 64;
    localparam int WORD_BITS        = 16;

    localparam int STORE_WORDS = MAX_BLOCK_WORDS * MAX_DEPTH_BLOCKS;
    localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int POS_W       = (MAX_BLOCK_WORDS > 1) ? $clog2(MAX_BLOCK_WORDS) : 1;
    localparam int BLK_W       = (MAX_DEPTH_BLOCKS > 1) ? $clog2(MAX_DEPTH_BLOCKS) : 1;
    localparam int WCNT_W      = $clog2(MAX_BLOCK_WORDS + 1);
    localparam int CNT_W       = $clog2(MAX_DEPTH_BLOCKS + 1);

    // fixed field widths
    localparam int ACT_W     = 2;
    localparam int DATA_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int HELD_W    = 7;
    localparam int BW_W      = 5;
    localparam int DEPTH_W   = 7;
    localparam int CFG_IDX_W = 2;

    // register reset values
    localparam logic [BW_W-1:0]    BW_RESET    = BW_W'(1);
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(64);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WORDS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_BLOCKS = CFG_IDX_W'(1);

    // action codes
    localparam logic [ACT_W-1:0] ACT_PUSH  = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_POP   = ACT_W'(1);
    localparam logic [ACT_W-1:0] ACT_CLEAR = ACT_W'(2);

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = STATUS_W'(2);

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        CMD_NOTE,
        CMD_WRITE,
        CMD_READ
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind           kind;
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
        t_word               word;
        logic [WCNT_W-1:0]   n;
        logic [HELD_W-1:0]   held;
        logic                full;
        logic                empty;
    } t_cmd;

endpackage

// ----- rtl/block_ring_fifo_top.sv -----
// Ring FIFO of fixed-size blocks of words. A front stage takes one item per cycle while the
// queue has room, checks it against the block pointers and count, and queues a command (up to
// four deep); a back stage runs the commands against the single-port word store. Push, clear,
// unused and rejected items give one result each and sustain one item per cycle while results
// are taken. A pop of a held block gives block_words results, one store read each, holding the
// back stage for all of them while the front keeps accepting until the queue fills. Results
// pass the queue, command register, read stage and output register. No clearing pass is needed
// after reset; the user writes configuration only while idle; the block does not enforce it.
module block_ring_fifo_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [brf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [brf_pkg::DEPTH_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [brf_pkg::ACT_W-1:0]      i_action,
    input  logic [brf_pkg::DATA_W-1:0]     i_data_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [brf_pkg::DATA_W-1:0]     o_data_out,
    output logic [brf_pkg::STATUS_W-1:0]   o_status,
    output logic                           o_last_word,
    output logic [brf_pkg::HELD_W-1:0]     o_blocks_held,
    output logic                           o_full_flag,
    output logic                           o_empty_flag
);

    logic          q_push;
    logic          q_ready;
    logic          q_valid;
    logic          q_pop;
    brf_pkg::t_cmd front_cmd;
    brf_pkg::t_cmd back_cmd;

    // item classification and pointer state
    brf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_data_word (i_data_word),
        .i_q_ready   (q_ready),
        .o_q_push    (q_push),
        .o_cmd       (front_cmd)
    );

    // command queue
    brf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (back_cmd)
    );

    // store access and result output
    brf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_cmd         (back_cmd),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_out    (o_data_out),
        .o_status      (o_status),
        .o_last_word   (o_last_word),
        .o_blocks_held (o_blocks_held),
        .o_full_flag   (o_full_flag),
        .o_empty_flag  (o_empty_flag)
    );

`ifndef SYNTHESIS
    // no result is left over from before reset
    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a rejected item gives exactly one result with no data
    a_reject_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != brf_pkg::ST_OK) |-> (o_last_word && o_data_out == '0))
        else $error("rejected item result is not a single empty word");

    // a push is refused only when the reported state is full
    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == brf_pkg::ST_PUSH_FULL) |-> o_full_flag)
        else $error("push refused while not full");

    // a pop is refused only when nothing is held
    a_empty_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == brf_pkg::ST_POP_EMPTY)
        |-> (o_empty_flag && o_blocks_held == '0 && !o_full_flag))
        else $error("pop refused while blocks are held");
`endif

endmodule

// ----- rtl/brf_front.sv -----
module brf_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [brf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [brf_pkg::DEPTH_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [brf_pkg::ACT_W-1:0]       i_action,
    input  logic [brf_pkg::DATA_W-1:0]      i_data_word,
    input  logic                            i_q_ready,
    output logic                            o_q_push,
    output brf_pkg::t_cmd                   o_cmd
);

    logic [brf_pkg::BW_W-1:0]    r_bw;
    logic [brf_pkg::DEPTH_W-1:0] r_depth;
    logic [brf_pkg::BLK_W-1:0]   r_wb, n_wb;
    logic [brf_pkg::BLK_W-1:0]   r_rb, n_rb;
    logic [brf_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [brf_pkg::CNT_W-1:0]   r_cnt, n_cnt;

    logic [brf_pkg::WCNT_W-1:0]  eff_words;
    logic [brf_pkg::CNT_W-1:0]   eff_depth;
    logic [brf_pkg::WCNT_W-1:0]  pos_inc;
    logic                        accept;

    // block pointer advance with wrap at the live depth
    function automatic logic [brf_pkg::BLK_W-1:0] next_blk(
        input logic [brf_pkg::BLK_W-1:0] b,
        input logic [brf_pkg::CNT_W-1:0] d
    );
        logic [brf_pkg::BLK_W:0] inc;
        inc = {1'b0, b} + (brf_pkg::BLK_W + 1)'(1);
        if (inc >= d) return '0;
        return inc[brf_pkg::BLK_W-1:0];
    endfunction

    // word address of the first word of a block slot
    function automatic logic [brf_pkg::ADDR_W-1:0] blk_base(
        input logic [brf_pkg::BLK_W-1:0] b
    );
        return brf_pkg::ADDR_W'(b) * brf_pkg::ADDR_W'(brf_pkg::MAX_BLOCK_WORDS);
    endfunction

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;
    assign o_q_push   = accept;

    // clamp configuration to its working range
    always_comb begin
        if (r_bw == '0) begin
            eff_words = brf_pkg::WCNT_W'(1);
        end else if (int'(r_bw) > brf_pkg::MAX_BLOCK_WORDS) begin
            eff_words = brf_pkg::WCNT_W'(brf_pkg::MAX_BLOCK_WORDS);
        end else begin
            eff_words = brf_pkg::WCNT_W'(r_bw);
        end
        if (r_depth == '0) begin
            eff_depth = brf_pkg::CNT_W'(1);
        end else if (int'(r_depth) > brf_pkg::MAX_DEPTH_BLOCKS) begin
            eff_depth = brf_pkg::CNT_W'(brf_pkg::MAX_DEPTH_BLOCKS);
        end else begin
            eff_depth = brf_pkg::CNT_W'(r_depth);
        end
    end

    assign pos_inc = brf_pkg::WCNT_W'(r_pos) + brf_pkg::WCNT_W'(1);

    // classify the item, build its command and the next pointer state
    always_comb begin
        n_wb  = r_wb;
        n_rb  = r_rb;
        n_pos = r_pos;
        n_cnt = r_cnt;
        o_cmd.kind   = brf_pkg::CMD_NOTE;
        o_cmd.status = brf_pkg::ST_OK;
        o_cmd.addr   = '0;
        o_cmd.word   = brf_pkg::t_word'(i_data_word);
        o_cmd.n      = eff_words;
        case (i_action)
            brf_pkg::ACT_PUSH: begin
                if (r_pos == '0 && r_cnt >= eff_depth) begin
                    o_cmd.status = brf_pkg::ST_PUSH_FULL;
                end else begin
                    o_cmd.kind = brf_pkg::CMD_WRITE;
                    o_cmd.addr = blk_base(r_wb) + brf_pkg::ADDR_W'(r_pos);
                    if (pos_inc >= eff_words) begin
                        n_pos = '0;
                        n_wb  = next_blk(r_wb, eff_depth);
                        n_cnt = r_cnt + brf_pkg::CNT_W'(1);
                    end else begin
                        n_pos = brf_pkg::POS_W'(pos_inc);
                    end
                end
            end
            brf_pkg::ACT_POP: begin
                if (r_cnt == '0) begin
                    o_cmd.status = brf_pkg::ST_POP_EMPTY;
                end else begin
                    o_cmd.kind = brf_pkg::CMD_READ;
                    o_cmd.addr = blk_base(r_rb);
                    n_rb  = next_blk(r_rb, eff_depth);
                    n_cnt = r_cnt - brf_pkg::CNT_W'(1);
                end
            end
            brf_pkg::ACT_CLEAR: begin
                n_wb  = '0;
                n_rb  = '0;
                n_pos = '0;
                n_cnt = '0;
            end
            default: begin
            end
        endcase
        o_cmd.held  = brf_pkg::HELD_W'(n_cnt);
        o_cmd.full  = (n_cnt >= eff_depth);
        o_cmd.empty = (n_cnt == '0);
    end

    // pointer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb  <= '0;
            r_rb  <= '0;
            r_pos <= '0;
            r_cnt <= '0;
        end else if (accept) begin
            r_wb  <= n_wb;
            r_rb  <= n_rb;
            r_pos <= n_pos;
            r_cnt <= n_cnt;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw    <= brf_pkg::BW_RESET;
            r_depth <= brf_pkg::DEPTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                brf_pkg::CFG_BLOCK_WORDS:  r_bw    <= i_cfg_data[brf_pkg::BW_W-1:0];
                brf_pkg::CFG_DEPTH_BLOCKS: r_depth <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/brf_queue.sv -----
module brf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  brf_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_pop,
    output brf_pkg::t_cmd o_cmd
);

    brf_pkg::t_cmd               r_mem [brf_pkg::Q_DEPTH];
    logic [brf_pkg::Q_PTR_W-1:0] r_wptr;
    logic [brf_pkg::Q_PTR_W-1:0] r_rptr;
    logic [brf_pkg::Q_CNT_W-1:0] r_cnt;
    logic                        do_push;
    logic                        do_pop;

    function automatic logic [brf_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [brf_pkg::Q_PTR_W-1:0] p
    );
        if (p == brf_pkg::Q_PTR_W'(brf_pkg::Q_DEPTH - 1)) return '0;
        return p + brf_pkg::Q_PTR_W'(1);
    endfunction

    assign o_ready = (r_cnt != brf_pkg::Q_CNT_W'(brf_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // command storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) r_wptr <= ptr_inc(r_wptr);
            if (do_pop)  r_rptr <= ptr_inc(r_rptr);
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + brf_pkg::Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - brf_pkg::Q_CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/brf_back.sv -----
module brf_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  brf_pkg::t_cmd                  i_cmd,
    output logic                           o_q_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [brf_pkg::DATA_W-1:0]     o_data_out,
    output logic [brf_pkg::STATUS_W-1:0]   o_status,
    output logic                           o_last_word,
    output logic [brf_pkg::HELD_W-1:0]     o_blocks_held,
    output logic                           o_full_flag,
    output logic                           o_empty_flag
);

    // word store
    brf_pkg::t_word r_store [brf_pkg::STORE_WORDS];
    brf_pkg::t_word r_rdata;

    // command in progress
    logic                         r_cmd_vld;
    brf_pkg::t_cmd                r_cmd;
    logic [brf_pkg::WCNT_W-1:0]   r_idx;

    // read stage, waits for store data
    logic                         r_rd_vld;
    logic                         r_rd_is_read;
    logic [brf_pkg::STATUS_W-1:0] r_rd_status;
    logic                         r_rd_last;
    logic [brf_pkg::HELD_W-1:0]   r_rd_held;
    logic                         r_rd_full;
    logic                         r_rd_empty;

    // output register
    logic                         r_out_vld;
    logic [brf_pkg::DATA_W-1:0]   r_out_data;
    logic [brf_pkg::STATUS_W-1:0] r_out_status;
    logic                         r_out_last;
    logic [brf_pkg::HELD_W-1:0]   r_out_held;
    logic                         r_out_full;
    logic                         r_out_empty;

    logic                         rd_move;
    logic                         issue;
    logic                         is_last;
    logic                         done;
    logic [brf_pkg::WCNT_W-1:0]   idx_inc;
    logic [brf_pkg::ADDR_W-1:0]   rd_addr;

    assign rd_move = r_rd_vld && (!r_out_vld || i_out_ready);
    assign issue   = r_cmd_vld && (!r_rd_vld || rd_move);
    assign idx_inc = r_idx + brf_pkg::WCNT_W'(1);
    assign is_last = (r_cmd.kind != brf_pkg::CMD_READ) || (idx_inc == r_cmd.n);
    assign done    = issue && is_last;
    assign o_q_pop = i_q_valid && (!r_cmd_vld || done);
    assign rd_addr = r_cmd.addr + brf_pkg::ADDR_W'(r_idx);

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (issue && r_cmd.kind == brf_pkg::CMD_WRITE) begin
            r_store[r_cmd.addr] <= r_cmd.word;
        end
        if (issue && r_cmd.kind == brf_pkg::CMD_READ) begin
            r_rdata <= r_store[rd_addr];
        end
    end

    // command sequencing, one result per issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
        end else if (o_q_pop) begin
            r_cmd_vld <= 1'b1;
        end else if (done) begin
            r_cmd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_cmd;
            r_idx <= '0;
        end else if (issue) begin
            r_idx <= idx_inc;
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (issue) begin
            r_rd_vld <= 1'b1;
        end else if (rd_move) begin
            r_rd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_is_read <= (r_cmd.kind == brf_pkg::CMD_READ);
            r_rd_status  <= r_cmd.status;
            r_rd_last    <= is_last;
            r_rd_held    <= r_cmd.held;
            r_rd_full    <= r_cmd.full;
            r_rd_empty   <= r_cmd.empty;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (rd_move) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_move) begin
            r_out_data   <= r_rd_is_read ? brf_pkg::DATA_W'(r_rdata) : '0;
            r_out_status <= r_rd_status;
            r_out_last   <= r_rd_last;
            r_out_held   <= r_rd_held;
            r_out_full   <= r_rd_full;
            r_out_empty  <= r_rd_empty;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_data_out    = r_out_data;
    assign o_status      = r_out_status;
    assign o_last_word   = r_out_last;
    assign o_blocks_held = r_out_held;
    assign o_full_flag   = r_out_full;
    assign o_empty_flag  = r_out_empty;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import brf_pkg::*;

    // action value with no meaning: the block answers ok and changes nothing
    localparam logic [ACT_W-1:0]     ACT_UNUSED     = ACT_W'(3);
    // register indexes that hold no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI   = CFG_IDX_W'(3);

    localparam int QUIET_LIMIT     = 5000;
    localparam int LONG_HOLD       = 400;
    localparam int N_PHASES        = 7;
    localparam int ITEMS_PER_PHASE = 58;
    localparam int TAIL_CYCLES     = 20;

    typedef struct packed {
        logic [DATA_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic                last_word;
        logic [HELD_W-1:0]   held;
        logic                full;
        logic                empty;
    } t_fifo_result;

    // predicts the block ring and checks each result transfer against it
    class ring_fifo_scoreboard;
        t_word              word_mem [STORE_WORDS];
        bit                 word_written [STORE_WORDS];
        int                 wr_blk;
        int                 rd_blk;
        int                 wr_pos;
        int                 held;
        logic [BW_W-1:0]    words_reg;
        logic [DEPTH_W-1:0] depth_reg;
        t_fifo_result       expected_results [$];
        int                 errors;
        int                 n_items;
        int                 n_results;
        int                 n_words_out;
        int                 n_full;
        int                 n_empty;
        int                 n_clears;

        function new();
            words_reg = BW_RESET;
            depth_reg = DEPTH_RESET;
        endfunction

        // out-of-range register values saturate
        function int eff_words();
            if (words_reg < 1) return 1;
            if (words_reg > MAX_BLOCK_WORDS) return MAX_BLOCK_WORDS;
            return int'(words_reg);
        endfunction

        function int eff_depth();
            if (depth_reg < 1) return 1;
            if (depth_reg > MAX_DEPTH_BLOCKS) return MAX_DEPTH_BLOCKS;
            return int'(depth_reg);
        endfunction

        function int next_blk(int b);
            return (b + 1 >= eff_depth()) ? 0 : b + 1;
        endfunction

        function int word_addr(int blk, int pos);
            return (blk * MAX_BLOCK_WORDS + pos) % STORE_WORDS;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DEPTH_W-1:0] val);
            if (idx == CFG_BLOCK_WORDS) begin
                words_reg = val[BW_W-1:0];
            end else if (idx == CFG_DEPTH_BLOCKS) begin
                depth_reg = val;
            end
        endfunction

        // flags and count are those after the step
        function void add_result(logic [DATA_W-1:0] data, logic [STATUS_W-1:0] status,
                                 logic last_word);
            t_fifo_result r;
            r.data      = data;
            r.status    = status;
            r.last_word = last_word;
            r.held      = HELD_W'(held);
            r.full      = (held >= eff_depth());
            r.empty     = (held == 0);
            expected_results.push_back(r);
        endfunction

        // a pop of the oldest block would touch a word never stored
        function bit pop_hits_unwritten();
            int blk;
            if (held == 0) return 1'b0;
            blk = rd_blk % MAX_DEPTH_BLOCKS;
            for (int i = 0; i < eff_words(); i++) begin
                if (!word_written[word_addr(blk, i)]) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void apply_item(logic [ACT_W-1:0] act, logic [DATA_W-1:0] word);
            int a;
            int blk;
            int n;
            n_items++;
            case (act)
                ACT_PUSH: begin
                    // only the first word of a block sees the full check
                    if (wr_pos == 0 && held >= eff_depth()) begin
                        n_full++;
                        add_result('0, ST_PUSH_FULL, 1'b1);
                    end else begin
                        a = word_addr(wr_blk % MAX_DEPTH_BLOCKS, wr_pos);
                        word_mem[a]     = t_word'(word);
                        word_written[a] = 1'b1;
                        wr_pos++;
                        if (wr_pos >= eff_words()) begin
                            wr_pos = 0;
                            wr_blk = next_blk(wr_blk);
                            held++;
                        end
                        add_result('0, ST_OK, 1'b1);
                    end
                end
                ACT_POP: begin
                    n   = eff_words();
                    blk = rd_blk % MAX_DEPTH_BLOCKS;
                    if (held == 0) begin
                        n_empty++;
                        add_result('0, ST_POP_EMPTY, 1'b1);
                    end else begin
                        rd_blk = next_blk(rd_blk);
                        held--;
                        n_words_out += n;
                        for (int i = 0; i < n; i++) begin
                            add_result(DATA_W'(word_mem[word_addr(blk, i)]), ST_OK, i == n - 1);
                        end
                    end
                end
                ACT_CLEAR: begin
                    // pointers and count only, stored words stay
                    wr_blk = 0;
                    rd_blk = 0;
                    wr_pos = 0;
                    held   = 0;
                    n_clears++;
                    add_result('0, ST_OK, 1'b1);
                end
                default: begin
                    add_result('0, ST_OK, 1'b1);
                end
            endcase
        endfunction

        function void check_result(t_fifo_result got);
            t_fifo_result want;
            n_results++;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: data_out %h status %0d",
                       got.data, got.status);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.data !== want.data) begin
                $error("data_out: expected %h, got %h", want.data, got.data);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.last_word !== want.last_word) begin
                $error("last_word: expected %0b, got %0b", want.last_word, got.last_word);
                errors++;
            end
            if (got.held !== want.held) begin
                $error("blocks_held: expected %0d, got %0d", want.held, got.held);
                errors++;
            end
            if (got.full !== want.full) begin
                $error("full_flag: expected %0b, got %0b", want.full, got.full);
                errors++;
            end
            if (got.empty !== want.empty) begin
                $error("empty_flag: expected %0b, got %0b", want.empty, got.empty);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [DEPTH_W-1:0]      i_cfg_data    = '0;
    logic                    i_in_valid    = 1'b0;
    logic                    o_in_ready;
    logic [ACT_W-1:0]        i_action      = '0;
    logic [DATA_W-1:0]       i_data_word   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready   = 1'b0;
    logic [DATA_W-1:0]       o_data_out;
    logic [STATUS_W-1:0]     o_status;
    logic                    o_last_word;
    logic [HELD_W-1:0]       o_blocks_held;
    logic                    o_full_flag;
    logic                    o_empty_flag;

    ring_fifo_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_reqs      = 0;
    int hold_done      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int n_cfg_writes   = 0;

    block_ring_fifo_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_data_word   (i_data_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_out    (o_data_out),
        .o_status      (o_status),
        .o_last_word   (o_last_word),
        .o_blocks_held (o_blocks_held),
        .o_full_flag   (o_full_flag),
        .o_empty_flag  (o_empty_flag)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && hold_reqs != hold_done) begin
                hold_done = hold_reqs;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // monitor: results are checked before the input transfer of the same edge is applied
    always @(posedge i_clk) begin
        t_fifo_result got;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.data      = o_data_out;
                got.status    = o_status;
                got.last_word = o_last_word;
                got.held      = o_blocks_held;
                got.full      = o_full_flag;
                got.empty     = o_empty_flag;
                sb.check_result(got);
            end
            if (i_in_valid && o_in_ready) begin
                sb.apply_item(i_action, i_data_word);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL block_ring_fifo_top");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return DATA_W'($urandom());
        endcase
    endfunction

    // entered and left at a falling edge; returns once the transfer has been applied
    task automatic send_item(logic [ACT_W-1:0] act, logic [DATA_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_data_word <= word;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stop offering and wait for every expected result
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DEPTH_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        n_cfg_writes++;
        @(negedge i_clk);
    endtask

    // mostly whole blocks and pops, with partial pushes, clears and unused actions
    task automatic run_random(int n_items);
        int sent;
        int r;
        int n;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 45) begin
                n = (sb.wr_pos == 0 && sb.held >= sb.eff_depth()) ? 1
                                                                    : sb.eff_words() - sb.wr_pos;
                if (n < 1) n = 1;
                repeat (n) send_item(ACT_PUSH, rand_word());
                sent += n;
            end else if (r < 55) begin
                send_item(ACT_PUSH, rand_word());
                sent++;
            end else if (r < 88) begin
                if (sb.pop_hits_unwritten()) begin
                    send_item(ACT_PUSH, rand_word());
                end else begin
                    send_item(ACT_POP, rand_word());
                end
                sent++;
            end else if (r < 95) begin
                send_item(ACT_CLEAR, rand_word());
                sent++;
            end else begin
                send_item(ACT_UNUSED, rand_word());
                sent++;
            end
        end
    endtask

    // stimulus
    initial begin
        int phase_words [N_PHASES];
        int phase_depth [N_PHASES];
        int w;
        int d;

        phase_words = '{31, 1, 16, -1, 0, -2, 3};
        phase_depth = '{127, 1, 2, -1, 64, -2, 3};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // writes to unused indexes change nothing
        cfg_write(CFG_SPARE_LO, '1);
        cfg_write(CFG_SPARE_HI, '1);

        // reset settings: empty pop, data extremes, unused action, clear
        send_item(ACT_POP, 16'h1234);
        send_item(ACT_PUSH, 16'h0000);
        send_item(ACT_PUSH, 16'hFFFF);
        send_item(ACT_POP, 16'h0000);
        send_item(ACT_UNUSED, 16'hFFFF);
        send_item(ACT_CLEAR, 16'h0000);
        send_item(ACT_POP, 16'h0000);
        drain();

        // zero registers act as one: single-block fifo, push rejected when full
        cfg_write(CFG_BLOCK_WORDS, '0);
        cfg_write(CFG_DEPTH_BLOCKS, '0);
        send_item(ACT_PUSH, 16'h1234);
        send_item(ACT_PUSH, 16'h4321);
        send_item(ACT_POP, 16'h0000);
        send_item(ACT_POP, 16'h0000);
        drain();

        // block size shrinks under a started block, which then completes on the next push
        cfg_write(CFG_BLOCK_WORDS, 7'd4);
        cfg_write(CFG_DEPTH_BLOCKS, 7'd2);
        send_item(ACT_PUSH, 16'hA5A5);
        send_item(ACT_PUSH, 16'h5A5A);
        drain();
        cfg_write(CFG_BLOCK_WORDS, 7'd2);
        send_item(ACT_PUSH, 16'h0F0F);
        send_item(ACT_POP, 16'h0000);
        send_item(ACT_PUSH, 16'hFFFF);
        send_item(ACT_PUSH, 16'h0000);
        send_item(ACT_POP, 16'hFFFF);
        drain();

        // random phases over settings and idling patterns
        for (int p = 0; p < N_PHASES; p++) begin
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 88;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 88;
                end
                default: begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase
            if (phase_words[p] == -1) w = $urandom_range(16, 1);
            else if (phase_words[p] == -2) w = $urandom_range(127);
            else w = phase_words[p];
            if (phase_depth[p] == -1) d = $urandom_range(8, 1);
            else if (phase_depth[p] == -2) d = $urandom_range(127);
            else d = phase_depth[p];
            cfg_write(CFG_BLOCK_WORDS, DEPTH_W'(w));
            cfg_write(CFG_DEPTH_BLOCKS, DEPTH_W'(d));
            // receiver holds off long enough for the input to back up
            if (p == 2) hold_reqs++;
            run_random(ITEMS_PER_PHASE);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.expected_results.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_results.size());
            sb.errors++;
        end

        $display("run covered %0d input transfers and %0d result transfers, %0d words popped",
                 sb.n_items, sb.n_results, sb.n_words_out);
        $display("%0d full rejects, %0d empty rejects, %0d clears, %0d register writes",
                 sb.n_full, sb.n_empty, sb.n_clears, n_cfg_writes);
        if (sb.errors == 0) begin
            $display("PASS block_ring_fifo_top");
        end else begin
            $display("FAIL block_ring_fifo_top");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/brf_pkg.sv
rtl/brf_front.sv
rtl/brf_queue.sv
rtl/brf_back.sv
rtl/block_ring_fifo_top.sv
tb/testbench.sv
